>>> rtl/core/sdo_expedited_client_defines.svh
`ifndef SDO_EXPEDITED_CLIENT_DEFINES_SVH
`define SDO_EXPEDITED_CLIENT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDO_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("sdo assertion failed");
`define SDO_ASSERT_NXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("sdo assertion failed");
`else
`define SDO_ASSERT_IMP(lbl, c, r, a, b)
`define SDO_ASSERT_NXT(lbl, c, r, a, b)
`endif

`endif

>>> rtl/core/sdo_pkg.sv
package sdo_pkg;

	typedef enum logic [2:0] {
		CMD_READ  = 3'd0,
		CMD_WRITE = 3'd1,
		CMD_FRAME = 3'd2,
		CMD_TICK  = 3'd3,
		CMD_NMT   = 3'd4,
		CMD_SYNC  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_FRAME      = 3'd0,
		KIND_READ_DONE  = 3'd1,
		KIND_WRITE_DONE = 3'd2,
		KIND_ABORT      = 3'd3,
		KIND_TIMEOUT    = 3'd4,
		KIND_BUSY       = 3'd5
	} kind_t;

	localparam logic [1:0] REG_REQUEST_BASE  = 2'd0;
	localparam logic [1:0] REG_RESPONSE_BASE = 2'd1;
	localparam logic [1:0] REG_NMT_IDENT     = 2'd2;
	localparam logic [1:0] REG_SYNC_IDENT    = 2'd3;

	localparam logic [10:0] RST_REQUEST_BASE  = 11'd1536;
	localparam logic [10:0] RST_RESPONSE_BASE = 11'd1408;
	localparam logic [10:0] RST_NMT_IDENT     = 11'd0;
	localparam logic [10:0] RST_SYNC_IDENT    = 11'd128;

	localparam logic [7:0]  READ_REQ_BYTE  = 8'h40;
	localparam logic [7:0]  WRITE_REQ_BYTE = 8'h23;
	localparam logic [7:0]  ABORT_MASK     = 8'hE0;
	localparam logic [7:0]  ABORT_CMD      = 8'h80;
	localparam logic [15:0] TICK_MAX       = 16'hFFFF;
	localparam logic [2:0]  WORD_BYTES     = 3'd4;
	localparam logic [3:0]  SDO_LEN        = 4'd8;
	localparam logic [3:0]  NMT_LEN        = 4'd2;
	localparam logic [3:0]  SYNC_LEN       = 4'd0;

	typedef struct packed {
		logic [10:0] request_base;
		logic [10:0] response_base;
		logic [10:0] nmt_ident;
		logic [10:0] sync_ident;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [6:0]  node_id;
		logic [15:0] obj_index;
		logic [7:0]  obj_subindex;
		logic [31:0] write_value;
		logic [2:0]  write_size;
		logic [15:0] timeout_ticks;
		logic [10:0] rx_ident;
		logic [63:0] rx_payload;
		logic [7:0]  nmt_command;
	} item_t;

	typedef struct packed {
		logic        has;
		kind_t       kind;
		logic [10:0] tx_ident;
		logic [3:0]  tx_length;
		logic [63:0] tx_payload;
		logic [31:0] read_value;
		logic [31:0] abort_code;
	} result_t;

endpackage

>>> rtl/core/sdo_req_if.sv
interface sdo_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [6:0]  node_id;
	logic [15:0] obj_index;
	logic [7:0]  obj_subindex;
	logic [31:0] write_value;
	logic [2:0]  write_size;
	logic [15:0] timeout_ticks;
	logic [10:0] rx_ident;
	logic [63:0] rx_payload;
	logic [7:0]  nmt_command;

	modport source (
		output valid, cmd, node_id, obj_index, obj_subindex, write_value, write_size,
			timeout_ticks, rx_ident, rx_payload, nmt_command,
		input ready
	);
	modport sink (
		input valid, cmd, node_id, obj_index, obj_subindex, write_value, write_size,
			timeout_ticks, rx_ident, rx_payload, nmt_command,
		output ready
	);
endinterface

>>> rtl/core/sdo_rsp_if.sv
interface sdo_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [10:0] tx_ident;
	logic [3:0]  tx_length;
	logic [63:0] tx_payload;
	logic [31:0] read_value;
	logic [31:0] abort_code;

	modport source (
		output valid, result_kind, tx_ident, tx_length, tx_payload, read_value, abort_code,
		input ready
	);
	modport sink (
		input valid, result_kind, tx_ident, tx_length, tx_payload, read_value, abort_code,
		output ready
	);
endinterface

>>> rtl/core/sdo_expedited_client.sv
// Expedited SDO client with NMT and SYNC frame generation.
// req channel: one item per command (start read, start write, received frame,
//   tick, send NMT, send SYNC); accepted when req.valid and req.ready are high.
// rsp channel: zero or one result item per command item, in order: a frame to
//   send, read done, write done, abort, timeout or busy rejection.
// APB port: four 11-bit identifier registers at byte addresses 0, 4, 8, 12;
//   pready is always high, write only while no item is in flight.
// Flow: after acceptance the item moves from the input register into the
//   result register once that register can advance, and rsp.valid rises as
//   its result arrives there. The exchange state advances as the item leaves the
//   input register.
// Throughput: one item per cycle while rsp is not stalled, bounded by the
//   single decode and pack stage between the two registers.
// When rsp is stalled the result register holds its item and the input
//   register fills; req.ready drops only once both are full.
// Reset: identifiers take their default values, no exchange is pending and
//   both registers are empty.
`include "sdo_expedited_client_defines.svh"

module sdo_expedited_client (
	input  logic        clk,
	input  logic        arst_n,
	sdo_req_if.sink     req,
	sdo_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sdo_pkg::cfg_t    cfg;
	sdo_pkg::item_t   item_s1;
	sdo_pkg::result_t res;
	sdo_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             adv_s2;
	logic             proc;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign proc      = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;

	sdo_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdo_exchange u_xchg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.proc   (proc),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= proc && res.has;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd           <= req.cmd;
			item_s1.node_id       <= req.node_id;
			item_s1.obj_index     <= req.obj_index;
			item_s1.obj_subindex  <= req.obj_subindex;
			item_s1.write_value   <= req.write_value;
			item_s1.write_size    <= req.write_size;
			item_s1.timeout_ticks <= req.timeout_ticks;
			item_s1.rx_ident      <= req.rx_ident;
			item_s1.rx_payload    <= req.rx_payload;
			item_s1.nmt_command   <= req.nmt_command;
		end
		if (proc) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.result_kind = res_s2.kind;
	assign rsp.tx_ident    = res_s2.tx_ident;
	assign rsp.tx_length   = res_s2.tx_length;
	assign rsp.tx_payload  = res_s2.tx_payload;
	assign rsp.read_value  = res_s2.read_value;
	assign rsp.abort_code  = res_s2.abort_code;

	`SDO_ASSERT_IMP(a_full_stall_blocks_input, clk, arst_n,
		valid_s1 && valid_s2 && !rsp.ready, !req.ready)
	`SDO_ASSERT_NXT(a_stall_keeps_input, clk, arst_n,
		valid_s1 && valid_s2 && !rsp.ready, valid_s1)
	`SDO_ASSERT_NXT(a_stall_holds_result, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)

endmodule

>>> rtl/core/sdo_cfg_regs.sv
module sdo_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sdo_pkg::cfg_t       cfg
);

	sdo_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.request_base  <= sdo_pkg::RST_REQUEST_BASE;
			cfg_q.response_base <= sdo_pkg::RST_RESPONSE_BASE;
			cfg_q.nmt_ident     <= sdo_pkg::RST_NMT_IDENT;
			cfg_q.sync_ident    <= sdo_pkg::RST_SYNC_IDENT;
		end else if (wr_en) begin
			unique case (reg_sel)
				sdo_pkg::REG_REQUEST_BASE:  cfg_q.request_base  <= pwdata[10:0];
				sdo_pkg::REG_RESPONSE_BASE: cfg_q.response_base <= pwdata[10:0];
				sdo_pkg::REG_NMT_IDENT:     cfg_q.nmt_ident     <= pwdata[10:0];
				sdo_pkg::REG_SYNC_IDENT:    cfg_q.sync_ident    <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			sdo_pkg::REG_REQUEST_BASE:  prdata = {21'd0, cfg_q.request_base};
			sdo_pkg::REG_RESPONSE_BASE: prdata = {21'd0, cfg_q.response_base};
			sdo_pkg::REG_NMT_IDENT:     prdata = {21'd0, cfg_q.nmt_ident};
			sdo_pkg::REG_SYNC_IDENT:    prdata = {21'd0, cfg_q.sync_ident};
		endcase
	end

endmodule

>>> rtl/core/sdo_exchange.sv
`include "sdo_expedited_client_defines.svh"

module sdo_exchange (
	input  logic             clk,
	input  logic             arst_n,
	input  sdo_pkg::cfg_t    cfg,
	input  sdo_pkg::item_t   item,
	input  logic             proc,
	output sdo_pkg::result_t res
);

	logic        busy_q;
	logic        pending_is_write_q;
	logic [6:0]  pending_node_q;
	logic [15:0] elapsed_ticks_q;
	logic [15:0] limit_ticks_q;

	logic        busy_d;
	logic        pending_is_write_d;
	logic [6:0]  pending_node_d;
	logic [15:0] elapsed_ticks_d;
	logic [15:0] limit_ticks_d;

	logic [10:0] req_ident;
	logic [10:0] rsp_ident;
	logic [2:0]  size_diff;
	logic [7:0]  byte0;
	logic [31:0] upper;
	logic [15:0] tick_next;
	logic        is_start;

	assign req_ident = cfg.request_base + {4'd0, item.node_id};
	assign rsp_ident = cfg.response_base + {4'd0, pending_node_q};
	assign size_diff = sdo_pkg::WORD_BYTES - item.write_size;
	assign upper     = item.rx_payload[63:32];
	assign tick_next = (elapsed_ticks_q == sdo_pkg::TICK_MAX) ? elapsed_ticks_q
		: elapsed_ticks_q + 16'd1;
	assign is_start  = (item.cmd == sdo_pkg::CMD_READ) || (item.cmd == sdo_pkg::CMD_WRITE);

	always_comb begin
		res                = '0;
		busy_d             = busy_q;
		pending_is_write_d = pending_is_write_q;
		pending_node_d     = pending_node_q;
		elapsed_ticks_d    = elapsed_ticks_q;
		limit_ticks_d      = limit_ticks_q;
		byte0              = (item.cmd == sdo_pkg::CMD_WRITE)
			? (sdo_pkg::WRITE_REQ_BYTE | {4'd0, size_diff[1:0], 2'd0})
			: sdo_pkg::READ_REQ_BYTE;
		unique case (item.cmd)
			sdo_pkg::CMD_READ, sdo_pkg::CMD_WRITE: begin
				res.has = 1'b1;
				if (busy_q) begin
					res.kind = sdo_pkg::KIND_BUSY;
				end else begin
					res.kind       = sdo_pkg::KIND_FRAME;
					res.tx_ident   = req_ident;
					res.tx_length  = sdo_pkg::SDO_LEN;
					res.tx_payload = {
						(item.cmd == sdo_pkg::CMD_WRITE) ? item.write_value : 32'd0,
						item.obj_subindex, item.obj_index[15:8], item.obj_index[7:0], byte0};
					busy_d             = 1'b1;
					pending_is_write_d = (item.cmd == sdo_pkg::CMD_WRITE);
					pending_node_d     = item.node_id;
					elapsed_ticks_d    = 16'd0;
					limit_ticks_d      = item.timeout_ticks;
				end
			end
			sdo_pkg::CMD_FRAME: begin
				if (busy_q && (elapsed_ticks_q < limit_ticks_q) && (item.rx_ident == rsp_ident)) begin
					res.has = 1'b1;
					busy_d  = 1'b0;
					if ((item.rx_payload[7:0] & sdo_pkg::ABORT_MASK) == sdo_pkg::ABORT_CMD) begin
						res.kind       = sdo_pkg::KIND_ABORT;
						res.abort_code = upper;
					end else if (pending_is_write_q) begin
						res.kind = sdo_pkg::KIND_WRITE_DONE;
					end else begin
						res.kind       = sdo_pkg::KIND_READ_DONE;
						res.read_value = upper;
					end
				end
			end
			sdo_pkg::CMD_TICK: begin
				if (busy_q) begin
					elapsed_ticks_d = tick_next;
					if (tick_next >= limit_ticks_q) begin
						res.has  = 1'b1;
						res.kind = sdo_pkg::KIND_TIMEOUT;
						busy_d   = 1'b0;
					end
				end
			end
			sdo_pkg::CMD_NMT: begin
				res.has        = 1'b1;
				res.kind       = sdo_pkg::KIND_FRAME;
				res.tx_ident   = cfg.nmt_ident;
				res.tx_length  = sdo_pkg::NMT_LEN;
				res.tx_payload = {49'd0, item.node_id, item.nmt_command};
			end
			sdo_pkg::CMD_SYNC: begin
				res.has       = 1'b1;
				res.kind      = sdo_pkg::KIND_FRAME;
				res.tx_ident  = cfg.sync_ident;
				res.tx_length = sdo_pkg::SYNC_LEN;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q             <= 1'b0;
			pending_is_write_q <= 1'b0;
			pending_node_q     <= 7'd0;
			elapsed_ticks_q    <= 16'd0;
			limit_ticks_q      <= 16'd0;
		end else if (proc) begin
			busy_q             <= busy_d;
			pending_is_write_q <= pending_is_write_d;
			pending_node_q     <= pending_node_d;
			elapsed_ticks_q    <= elapsed_ticks_d;
			limit_ticks_q      <= limit_ticks_d;
		end
	end

	`SDO_ASSERT_IMP(a_reject_only_busy, clk, arst_n,
		proc && is_start && !busy_q, res.kind == sdo_pkg::KIND_FRAME)
	`SDO_ASSERT_NXT(a_start_sets_busy, clk, arst_n, proc && is_start, busy_q)
	`SDO_ASSERT_NXT(a_timeout_clears_busy, clk, arst_n,
		proc && res.has && (res.kind == sdo_pkg::KIND_TIMEOUT), !busy_q)

endmodule

>>> tb/tb.sv
module tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sdo_req_if req ();
	sdo_rsp_if rsp ();

	sdo_expedited_client DUT (
		.clk,
		.arst_n,
		.req     (req),
		.rsp     (rsp),
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	logic [10:0] id_request  = sdo_pkg::RST_REQUEST_BASE;
	logic [10:0] id_response = sdo_pkg::RST_RESPONSE_BASE;
	logic [10:0] id_nmt      = sdo_pkg::RST_NMT_IDENT;
	logic [10:0] id_sync     = sdo_pkg::RST_SYNC_IDENT;

	logic        xchg_busy    = 1'b0;
	logic        xchg_write   = 1'b0;
	logic [6:0]  xchg_node    = '0;
	logic [15:0] xchg_elapsed = '0;
	logic [15:0] xchg_limit   = '0;

	sdo_pkg::item_t   send_q[$];
	sdo_pkg::result_t due_results[$];
	int      queued_cnt = 0;
	int      taken_cnt = 0;
	int      errors = 0;
	int      quiet_cycles = 0;
	int      send_gap = 0;
	int      hold_gap = 0;
	bit      req_took = 1'b0;
	bit      idle_en = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic sdo_pkg::result_t client_response(sdo_pkg::item_t it);
		sdo_pkg::result_t r;
		logic [2:0] spare;
		logic [7:0] head;
		r = '0;
		r.kind = sdo_pkg::KIND_FRAME;
		case (it.cmd)
			sdo_pkg::CMD_READ, sdo_pkg::CMD_WRITE: begin
				r.has = 1'b1;
				if (xchg_busy) begin
					r.kind = sdo_pkg::KIND_BUSY;
				end else begin
					spare = sdo_pkg::WORD_BYTES - it.write_size;
					head = (it.cmd == sdo_pkg::CMD_WRITE) ?
						(sdo_pkg::WRITE_REQ_BYTE | {4'b0, spare[1:0], 2'b0})
						: sdo_pkg::READ_REQ_BYTE;
					r.tx_ident = id_request + 11'(it.node_id);
					r.tx_length = sdo_pkg::SDO_LEN;
					r.tx_payload = {(it.cmd == sdo_pkg::CMD_WRITE) ? it.write_value : 32'h0,
						it.obj_subindex, it.obj_index[15:8], it.obj_index[7:0], head};
					xchg_busy = 1'b1;
					xchg_write = (it.cmd == sdo_pkg::CMD_WRITE);
					xchg_node = it.node_id;
					xchg_elapsed = '0;
					xchg_limit = it.timeout_ticks;
				end
			end
			sdo_pkg::CMD_FRAME: begin
				if (xchg_busy && xchg_elapsed < xchg_limit &&
						it.rx_ident == 11'(id_response + 11'(xchg_node))) begin
					xchg_busy = 1'b0;
					r.has = 1'b1;
					if ((it.rx_payload[7:0] & sdo_pkg::ABORT_MASK) == sdo_pkg::ABORT_CMD) begin
						r.kind = sdo_pkg::KIND_ABORT;
						r.abort_code = it.rx_payload[63:32];
					end else if (xchg_write) begin
						r.kind = sdo_pkg::KIND_WRITE_DONE;
					end else begin
						r.kind = sdo_pkg::KIND_READ_DONE;
						r.read_value = it.rx_payload[63:32];
					end
				end
			end
			sdo_pkg::CMD_TICK: begin
				if (xchg_busy) begin
					if (xchg_elapsed != sdo_pkg::TICK_MAX)
						xchg_elapsed++;
					if (xchg_elapsed >= xchg_limit) begin
						xchg_busy = 1'b0;
						r.has = 1'b1;
						r.kind = sdo_pkg::KIND_TIMEOUT;
					end
				end
			end
			sdo_pkg::CMD_NMT: begin
				r.has = 1'b1;
				r.tx_ident = id_nmt;
				r.tx_length = sdo_pkg::NMT_LEN;
				r.tx_payload = {49'b0, it.node_id, it.nmt_command};
			end
			sdo_pkg::CMD_SYNC: begin
				r.has = 1'b1;
				r.tx_ident = id_sync;
				r.tx_length = sdo_pkg::SYNC_LEN;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	function automatic sdo_pkg::item_t any_item(logic [2:0] c);
		sdo_pkg::item_t it;
		it.cmd = c;
		it.node_id = 7'($urandom);
		it.obj_index = 16'($urandom);
		it.obj_subindex = 8'($urandom);
		it.write_value = $urandom;
		it.write_size = 3'($urandom);
		it.timeout_ticks = 16'($urandom);
		it.rx_ident = 11'($urandom);
		it.rx_payload = {$urandom, $urandom};
		it.nmt_command = 8'($urandom);
		return it;
	endfunction

	function automatic sdo_pkg::item_t start_of(sdo_pkg::cmd_t c, logic [6:0] node,
			logic [15:0] tmo);
		sdo_pkg::item_t it;
		it = any_item(c);
		it.node_id = node;
		it.timeout_ticks = tmo;
		return it;
	endfunction

	function automatic sdo_pkg::item_t reply_to(logic [6:0] node, logic [63:0] pl);
		sdo_pkg::item_t it;
		it = any_item(sdo_pkg::CMD_FRAME);
		it.rx_ident = id_response + {4'b0, node};
		it.rx_payload = pl;
		return it;
	endfunction

	task automatic add(sdo_pkg::item_t it);
		send_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic add_exchange();
		logic [6:0]  node;
		logic [15:0] tmo;
		logic [63:0] pl;
		int          ticks;
		bit          long_wait;
		sdo_pkg::item_t it;
		node = 7'($urandom);
		long_wait = ($urandom_range(0, 9) == 0);
		tmo = long_wait ? 16'($urandom_range(7, 65535)) : 16'($urandom_range(0, 6));
		add(start_of($urandom_range(0, 1) ? sdo_pkg::CMD_WRITE : sdo_pkg::CMD_READ, node, tmo));
		ticks = 0;
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				0: begin
					if (ticks + 1 < int'(tmo)) begin
						add(any_item(sdo_pkg::CMD_TICK));
						ticks++;
					end else begin
						add(any_item(sdo_pkg::CMD_SYNC));
					end
				end
				1: begin
					it = reply_to(node, {$urandom, $urandom});
					it.rx_ident ^= 11'($urandom_range(1, 2047));
					add(it);
				end
				2: add(any_item(sdo_pkg::CMD_NMT));
				3: add(any_item(sdo_pkg::CMD_SYNC));
				4: add(any_item($urandom_range(0, 1) ? sdo_pkg::CMD_WRITE : sdo_pkg::CMD_READ));
				default: begin
					if (tmo == 0)
						add(reply_to(node, {$urandom, $urandom}));
					else
						add(any_item($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO));
				end
			endcase
		end
		if (int'(tmo) > ticks && (long_wait || $urandom_range(0, 3) != 0)) begin
			pl = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				pl[7:5] = 3'b100;
			add(reply_to(node, pl));
		end else begin
			repeat ((int'(tmo) > ticks) ? int'(tmo) - ticks : 1)
				add(any_item(sdo_pkg::CMD_TICK));
		end
	endtask

	task automatic add_random(int n);
		int useful;
		int mark;
		useful = 0;
		while (useful < n) begin
			mark = queued_cnt;
			add_exchange();
			useful += queued_cnt - mark;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3))
					add(any_item(3'($urandom_range(sdo_pkg::CMD_FRAME, CMD_SPARE_HI))));
			end
		end
	endtask

	task automatic drain();
		while (taken_cnt != queued_cnt || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {21'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		case (idx)
			sdo_pkg::REG_REQUEST_BASE:  id_request = val;
			sdo_pkg::REG_RESPONSE_BASE: id_response = val;
			sdo_pkg::REG_NMT_IDENT:     id_nmt = val;
			sdo_pkg::REG_SYNC_IDENT:    id_sync = val;
			default: begin
			end
		endcase
	endtask

	task automatic set_ids(logic [10:0] rq, logic [10:0] rs, logic [10:0] nm, logic [10:0] sy);
		write_reg(sdo_pkg::REG_REQUEST_BASE, rq);
		write_reg(sdo_pkg::REG_RESPONSE_BASE, rs);
		write_reg(sdo_pkg::REG_NMT_IDENT, nm);
		write_reg(sdo_pkg::REG_SYNC_IDENT, sy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		sdo_pkg::item_t head_item;
		if (arst_n && (!req.valid || req_took)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req.valid <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 6);
				req.valid <= 1'b0;
			end else if (send_q.size() != 0) begin
				head_item = send_q.pop_front();
				{req.cmd, req.node_id, req.obj_index, req.obj_subindex, req.write_value,
					req.write_size, req.timeout_ticks, req.rx_ident, req.rx_payload,
					req.nmt_command} <= head_item;
				req.valid <= 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_gap != 0) begin
			hold_gap <= hold_gap - 1;
			rsp.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			hold_gap <= $urandom_range(0, 6);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sdo_pkg::result_t want;
		sdo_pkg::item_t   seen;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d",
						$time, rsp.result_kind);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", want.kind, rsp.result_kind);
					check_field("tx_ident", want.tx_ident, rsp.tx_ident);
					check_field("tx_length", want.tx_length, rsp.tx_length);
					check_field("tx_payload", want.tx_payload, rsp.tx_payload);
					check_field("read_value", want.read_value, rsp.read_value);
					check_field("abort_code", want.abort_code, rsp.abort_code);
				end
			end
			if (req.valid && req.ready) begin
				seen = {req.cmd, req.node_id, req.obj_index, req.obj_subindex, req.write_value,
					req.write_size, req.timeout_ticks, req.rx_ident, req.rx_payload,
					req.nmt_command};
				want = client_response(seen);
				if (want.has)
					due_results.push_back(want);
				taken_cnt <= taken_cnt + 1;
			end
		end
		req_took <= req.valid && req.ready;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sdo_pkg::item_t it;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		{req.cmd, req.node_id, req.obj_index, req.obj_subindex, req.write_value,
			req.write_size, req.timeout_ticks, req.rx_ident, req.rx_payload,
			req.nmt_command} = '0;
		rsp.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		add(any_item(sdo_pkg::CMD_SYNC));
		it = any_item(sdo_pkg::CMD_NMT);
		it.node_id = '1;
		it.nmt_command = '1;
		add(it);
		it = any_item(sdo_pkg::CMD_NMT);
		it.node_id = '0;
		it.nmt_command = '0;
		add(it);
		add(any_item(sdo_pkg::CMD_TICK));
		add(reply_to(7'd0, {$urandom, $urandom}));
		add(any_item(CMD_SPARE_LO));
		add(any_item(CMD_SPARE_HI));
		it = start_of(sdo_pkg::CMD_READ, '1, '1);
		it.obj_index = '1;
		it.obj_subindex = '1;
		add(it);
		add(any_item(sdo_pkg::CMD_READ));
		add(any_item(sdo_pkg::CMD_WRITE));
		it = reply_to('1, {$urandom, $urandom});
		it.rx_ident = ~it.rx_ident;
		add(it);
		add(any_item(sdo_pkg::CMD_NMT));
		add(any_item(sdo_pkg::CMD_SYNC));
		add(any_item(sdo_pkg::CMD_TICK));
		add(reply_to('1, {32'hFFFF_FFFF, 24'h0, 8'h43}));
		it = start_of(sdo_pkg::CMD_WRITE, '0, 16'd1000);
		it.obj_index = '0;
		it.obj_subindex = '0;
		it.write_value = '1;
		it.write_size = 3'd0;
		add(it);
		// abort recognized under the mask, low bits set
		add(reply_to('0, {$urandom, 24'h0, 8'h9F}));
		add(start_of(sdo_pkg::CMD_WRITE, 7'd5, 16'd2));
		add(any_item(sdo_pkg::CMD_TICK));
		add(any_item(sdo_pkg::CMD_TICK));
		// zero limit: the response is dropped, the first tick times out
		add(start_of(sdo_pkg::CMD_READ, 7'd3, 16'd0));
		add(reply_to(7'd3, {$urandom, $urandom}));
		add(any_item(sdo_pkg::CMD_TICK));
		it = start_of(sdo_pkg::CMD_WRITE, 7'd64, 16'd3);
		it.write_size = 3'd7;
		add(it);
		add(reply_to(7'd64, {$urandom, 24'h0, 8'hA0}));
		drain();

		set_ids('1, '1, '1, '1);
		add_random(120);
		drain();

		set_ids('0, '0, '0, '0);
		add_random(120);
		drain();

		set_ids(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
		add_random(120);
		drain();

		set_ids(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
		idle_en <= 1'b0;
		add_random(100);
		drain();
		repeat (4) @(negedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sdo_pkg.sv
rtl/core/sdo_req_if.sv
rtl/core/sdo_rsp_if.sv
rtl/core/sdo_cfg_regs.sv
rtl/core/sdo_exchange.sv
rtl/core/sdo_expedited_client.sv
tb/tb.sv
